// ===== rtl/bfa_pkg.sv =====
// Shared constants for the block frame allocator.
`default_nettype none
package bfa_pkg;

    // Pool geometry
    localparam int NUM_BLOCKS = 64;
    localparam int ID_BITS    = 8;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    // Field widths of the channels
    localparam int FIRST_W    = 6;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Request codes
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAGING_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = CFG_IDX_W'(1);

    // Reset values of the configuration registers
    localparam logic             PAGING_RESET = 1'b1;
    localparam logic [COUNT_W-1:0] BLOCKS_RESET = COUNT_W'(64);

endpackage : bfa_pkg
`default_nettype wire

// ===== rtl/block_frame_allocator_unit.sv =====
// Top level of the block frame allocator: owner table, scan sequencer, result register.
//
//  channel | direction | handshake          | beat contents
//  s_      | in        | s_valid / s_ready  | req_type, process_id, block_count
//  m_      | out       | m_valid / m_ready  | granted, first_block, changed_count, used_blocks
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request scans the owner table one block per cycle on a single compare/count unit.
// Release: reads each block's owner id through the registered id memory read port, drops
// the owned blocks one behind the read, then passes through the final state to the result.
// Allocate: scans at most the managed blocks; it stops early once the request is met.
// Reset marks every block free at once through per-block valid flops; no clearing pass.
// While a result is held by m_ready low, the next request still scans, then waits in the final state with s_ready low.
`default_nettype none
module block_frame_allocator_unit
    import bfa_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // request channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_req_type,
    input  wire logic [ID_BITS-1:0]    s_process_id,
    input  wire logic [COUNT_W-1:0]    s_block_count,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_granted,
    output logic [FIRST_W-1:0]         m_first_block,
    output logic [COUNT_W-1:0]         m_changed_count,
    output logic [COUNT_W-1:0]         m_used_blocks,
    // configuration channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REL,
        ST_ALLOC,
        ST_FIN
    } state_t;

    // control state
    state_t                  state_reg,   state_next;
    logic [NUM_BLOCKS-1:0]   valid_reg,   valid_next;
    logic [CNT_W-1:0]        used_reg,    used_next;
    logic                    paging_reg,  paging_next;
    logic [COUNT_W-1:0]      blocks_reg,  blocks_next;
    logic                    rd_vld_reg,  rd_vld_next;
    logic                    m_valid_reg, m_valid_next;

    // working payload
    logic [ID_BITS-1:0]      pid_reg,     pid_next;
    logic [COUNT_W-1:0]      cnt_reg,     cnt_next;
    logic [CNT_W-1:0]        lim_reg,     lim_next;
    logic [CNT_W-1:0]        idx_reg,     idx_next;
    logic [CNT_W-1:0]        chg_reg,     chg_next;
    logic [IDX_W-1:0]        first_reg,   first_next;
    logic                    grant_reg,   grant_next;
    logic [NUM_BLOCKS-1:0]   pend_reg,    pend_next;

    // result register
    logic                    m_granted_reg, m_granted_next;
    logic [FIRST_W-1:0]      m_first_reg,   m_first_next;
    logic [COUNT_W-1:0]      m_chg_reg,     m_chg_next;
    logic [COUNT_W-1:0]      m_used_reg,    m_used_next;

    // owner id store
    logic [ID_BITS-1:0]      id_mem [NUM_BLOCKS];
    logic [ID_BITS-1:0]      id_rd_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic                    mem_we;
    logic [IDX_W-1:0]        ix;
    logic [CNT_W-1:0]        limit;

    assign ix = idx_reg[IDX_W-1:0];

    // Clamp the managed count to the pool size
    always_comb begin
        if (CNT_W'(blocks_reg) > CNT_W'(NUM_BLOCKS)) begin
            limit = CNT_W'(NUM_BLOCKS);
        end else begin
            limit = CNT_W'(blocks_reg);
        end
    end

    // Sequencer and scan unit
    always_comb begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        used_next      = used_reg;
        paging_next    = paging_reg;
        blocks_next    = blocks_reg;
        rd_vld_next    = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        pid_next       = pid_reg;
        cnt_next       = cnt_reg;
        lim_next       = lim_reg;
        idx_next       = idx_reg;
        chg_next       = chg_reg;
        first_next     = first_reg;
        grant_next     = grant_reg;
        pend_next      = pend_reg;
        m_granted_next = m_granted_reg;
        m_first_next   = m_first_reg;
        m_chg_next     = m_chg_reg;
        m_used_next    = m_used_reg;
        mem_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pid_next   = s_process_id;
                    cnt_next   = s_block_count;
                    lim_next   = limit;
                    idx_next   = '0;
                    chg_next   = '0;
                    first_next = '0;
                    grant_next = 1'b0;
                    pend_next  = '0;
                    if (s_req_type == REQ_RELEASE) begin
                        state_next = ST_REL;
                    end else if (s_block_count == '0) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_ALLOC;
                    end
                end
            end

            ST_REL: begin
                // issue the id read for the next block
                if (idx_reg != CNT_W'(NUM_BLOCKS)) begin
                    rd_vld_next = 1'b1;
                    idx_next    = idx_reg + CNT_W'(1);
                end
                // drop blocks owned by the process, one behind the read
                if (rd_vld_reg && valid_reg[rd_idx_reg] && (id_rd_reg == pid_reg)) begin
                    valid_next[rd_idx_reg] = 1'b0;
                    chg_next               = chg_reg + CNT_W'(1);
                end
                if (idx_reg == CNT_W'(NUM_BLOCKS)) begin
                    used_next  = used_reg - chg_next;
                    grant_next = 1'b1;
                    state_next = ST_FIN;
                end
            end

            ST_ALLOC: begin
                if (idx_reg == lim_reg) begin
                    // ran out of managed blocks: nothing changes
                    chg_next   = '0;
                    first_next = '0;
                    state_next = ST_FIN;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                    if (valid_reg[ix]) begin
                        // without paging, a used block breaks a contiguous run
                        if (!paging_reg) begin
                            pend_next = '0;
                            chg_next  = '0;
                        end
                    end else begin
                        // reserve the free block; its id is only seen once valid
                        mem_we        = 1'b1;
                        pend_next[ix] = 1'b1;
                        if (chg_reg == '0) begin
                            first_next = ix;
                        end
                        chg_next = chg_reg + CNT_W'(1);
                        if (chg_next == CNT_W'(cnt_reg)) begin
                            valid_next = valid_reg | pend_next;
                            used_next  = used_reg + chg_next;
                            grant_next = 1'b1;
                            state_next = ST_FIN;
                        end
                    end
                end
            end

            ST_FIN: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = grant_reg;
                    m_first_next   = FIRST_W'(first_reg);
                    m_chg_next     = COUNT_W'(chg_reg);
                    m_used_next    = COUNT_W'(used_reg);
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // configuration writes
        if (cfg_valid) begin
            if (cfg_index == REG_PAGING_MODE) begin
                paging_next = cfg_data[0];
            end else if (cfg_index == REG_BLOCKS_IN_USE) begin
                blocks_next = COUNT_W'(cfg_data);
            end
        end
    end

    // Control state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            used_reg    <= '0;
            paging_reg  <= PAGING_RESET;
            blocks_reg  <= BLOCKS_RESET;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            used_reg    <= used_next;
            paging_reg  <= paging_next;
            blocks_reg  <= blocks_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working payload and result fields
    always_ff @(posedge aclk) begin
        pid_reg       <= pid_next;
        cnt_reg       <= cnt_next;
        lim_reg       <= lim_next;
        idx_reg       <= idx_next;
        chg_reg       <= chg_next;
        first_reg     <= first_next;
        grant_reg     <= grant_next;
        pend_reg      <= pend_next;
        m_granted_reg <= m_granted_next;
        m_first_reg   <= m_first_next;
        m_chg_reg     <= m_chg_next;
        m_used_reg    <= m_used_next;
    end

    // Owner id memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            id_mem[ix] <= pid_reg;
        end
        id_rd_reg  <= id_mem[ix];
        rd_idx_reg <= ix;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_granted       = m_granted_reg;
    assign m_first_block   = m_first_reg;
    assign m_changed_count = m_chg_reg;
    assign m_used_blocks   = m_used_reg;

endmodule : block_frame_allocator_unit
`default_nettype wire

// ===== rtl/bfa_checker.sv =====
// Port-level checks for the block frame allocator, bound to the top level.
`default_nettype none
module bfa_checker
    import bfa_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic               m_granted,
    input wire logic [FIRST_W-1:0] m_first_block,
    input wire logic [COUNT_W-1:0] m_changed_count,
    input wire logic [COUNT_W-1:0] m_used_blocks
);

    // one request at a time: ready drops after each accepted beat
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while a previous one is in flight");

    // a stalled result beat holds its used count, changed count and granted flag
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_used_blocks)
                                   && $stable(m_changed_count) && $stable(m_granted)))
        else $error("result beat changed while stalled");

    // a refused allocation reports nothing taken
    a_refusal_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_granted) |-> (m_changed_count == '0 && m_first_block == '0))
        else $error("refused request reports blocks");

    // neither the used count nor the changed count exceeds the pool
    a_used_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_used_blocks <= COUNT_W'(NUM_BLOCKS)
                     && m_changed_count <= COUNT_W'(NUM_BLOCKS)))
        else $error("count beyond pool size");

endmodule : bfa_checker

bind block_frame_allocator_unit bfa_checker u_bfa_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_granted       (m_granted),
    .m_first_block   (m_first_block),
    .m_changed_count (m_changed_count),
    .m_used_blocks   (m_used_blocks)
);
`default_nettype wire
